@@ design/pheromone_grid_engine_top_defines.svh @@
// assertion macros for the pheromone grid engine
`ifndef PHEROMONE_GRID_ENGINE_TOP_DEFINES_SVH
`define PHEROMONE_GRID_ENGINE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define PGE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PGE_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PGE_ASSERT(lbl, prop, msg)
`define PGE_ASSERT_NR(lbl, prop, msg)
`endif
`endif

@@ design/pge_pkg.sv @@
// shared types, constants and tables of the pheromone grid engine
package pge_pkg;

  localparam int MAX_COLS    = 64;
  localparam int MAX_ROWS    = 64;
  localparam int LEVEL_BITS  = 16;
  localparam int COL_W       = $clog2(MAX_COLS);
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int GRID_W      = 7;
  localparam int LAYER_CELLS = MAX_COLS * MAX_ROWS;
  localparam int STORE_CELLS = 3 * LAYER_CELLS;
  localparam int ADDR_W      = $clog2(STORE_CELLS);
  localparam int DIVIDEND_W  = 15;
  localparam int DIVISOR_W   = 8;
  localparam int STEP_W      = $clog2(DIVIDEND_W);
  localparam int ANGLE_W     = 17;
  localparam int HEAD_W      = 15;

  localparam logic signed [ANGLE_W-1:0] Q12_PI      = 17'sd12868;
  localparam logic signed [ANGLE_W-1:0] Q12_HALF_PI = 17'sd6434;
  localparam logic signed [ANGLE_W-1:0] Q12_TWO_PI  = 17'sd25736;
  localparam logic [15:0]               PENALTY_Q16 = 16'd19661;

  localparam logic [2:0] REG_CELL_SIZE    = 3'd0;
  localparam logic [2:0] REG_GRID_COLS    = 3'd1;
  localparam logic [2:0] REG_GRID_ROWS    = 3'd2;
  localparam logic [2:0] REG_MAX_LEVEL    = 3'd3;
  localparam logic [2:0] REG_TRAIL_DECAY  = 3'd4;
  localparam logic [2:0] REG_DANGER_DECAY = 3'd5;
  localparam logic [2:0] REG_DETECT_LEVEL = 3'd6;

  typedef enum logic [2:0] {
    OP_DEPOSIT   = 3'd0,
    OP_EVAPORATE = 3'd1,
    OP_CLEAR     = 3'd2,
    OP_STRENGTH  = 3'd3,
    OP_DIRECTION = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_DIV, ST_DISPATCH, ST_DEP_RD, ST_DEP_WR, ST_EVAP,
    ST_CLEAR, ST_QRD, ST_QDATA, ST_DIR, ST_RESP
  } state_t;

  function automatic logic signed [1:0] nb_dx(input logic [2:0] k);
    case (k)
      3'd0, 3'd3, 3'd5: nb_dx = -2'sd1;
      3'd1, 3'd6:       nb_dx = 2'sd0;
      default:          nb_dx = 2'sd1;
    endcase
  endfunction

  function automatic logic signed [1:0] nb_dy(input logic [2:0] k);
    case (k)
      3'd0, 3'd1, 3'd2: nb_dy = -2'sd1;
      3'd3, 3'd4:       nb_dy = 2'sd0;
      default:          nb_dy = 2'sd1;
    endcase
  endfunction

  function automatic logic signed [ANGLE_W-1:0] nb_angle(input logic [2:0] k);
    case (k)
      3'd0:    nb_angle = -17'sd9651;
      3'd1:    nb_angle = -17'sd6434;
      3'd2:    nb_angle = -17'sd3217;
      3'd3:    nb_angle = 17'sd12868;
      3'd4:    nb_angle = 17'sd0;
      3'd5:    nb_angle = 17'sd9651;
      3'd6:    nb_angle = 17'sd6434;
      default: nb_angle = 17'sd3217;
    endcase
  endfunction

endpackage

@@ design/pge_div.sv @@
// restoring divider, one quotient bit per cycle
module pge_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [pge_pkg::DIVIDEND_W-1:0]    dividend,
  input  logic [pge_pkg::DIVISOR_W-1:0]     divisor,
  output logic                              done,
  output logic [pge_pkg::DIVIDEND_W-1:0]    quotient
);

  logic                              busy_r;
  logic                              done_r;
  logic [pge_pkg::STEP_W-1:0]        step_r;
  logic [pge_pkg::DIVIDEND_W-1:0]    quo_r;
  logic [pge_pkg::DIVISOR_W-1:0]     rem_r;
  logic [pge_pkg::DIVISOR_W-1:0]     div_r;
  logic [pge_pkg::DIVISOR_W:0]       trial;
  logic                              fits;

  assign trial = {rem_r, quo_r[pge_pkg::DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == pge_pkg::STEP_W'(pge_pkg::DIVIDEND_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[pge_pkg::DIVIDEND_W-2:0], fits};
      rem_r <= fits ? pge_pkg::DIVISOR_W'(trial - {1'b0, div_r})
                    : pge_pkg::DIVISOR_W'(trial);
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ design/pheromone_grid_engine_top.sv @@
// pheromone grid engine top level: config, control sequencer and cell memory
//
//  channel | ports                          | contents
//  in      | in_tvalid/in_tready            | tuser: opcode, layer_sel; tdata: position etc
//  out     | out_tvalid/out_tready          | tuser: reply_kind; tdata: level, found, dir_code
//  cfg     | cfg_wr_en/cfg_index/cfg_wdata  | register writes, no read-back
//
// position conversion runs a 15-step bit-serial divider for x and y in parallel
// evaporate and clear sweep the 12288-entry memory, which has one read port and one write port
// after reset a clearing pass over all 12288 entries runs before the first transaction
// one transaction at a time; a held result stalls only the next reply
`include "pheromone_grid_engine_top_defines.svh"
module pheromone_grid_engine_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,  // pos_x, pos_y, deposit_amount, bias_on, heading
  input  logic [4:0]  in_tuser,  // opcode, layer_sel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata, // level, found, dir_code, zero fill
  output logic        out_tuser, // reply_kind
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int AW = pge_pkg::ADDR_W;
  localparam int LW = pge_pkg::LEVEL_BITS;
  localparam int CW = pge_pkg::COL_W;
  localparam int RW = pge_pkg::ROW_W;
  localparam int GW = pge_pkg::GRID_W;

  // configuration
  logic [7:0]    cell_size_r;
  logic [GW-1:0] grid_cols_r, grid_rows_r;
  logic [LW-1:0] max_level_r, trail_decay_r, danger_decay_r, detect_level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_size_r    <= 8'd8;
      grid_cols_r    <= GW'(64);
      grid_rows_r    <= GW'(64);
      max_level_r    <= 16'd25600;
      trail_decay_r  <= 16'd65208;
      danger_decay_r <= 16'd64880;
      detect_level_r <= 16'd26;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        pge_pkg::REG_CELL_SIZE:    cell_size_r    <= cfg_wdata[7:0];
        pge_pkg::REG_GRID_COLS:    grid_cols_r    <= cfg_wdata[GW-1:0];
        pge_pkg::REG_GRID_ROWS:    grid_rows_r    <= cfg_wdata[GW-1:0];
        pge_pkg::REG_MAX_LEVEL:    max_level_r    <= cfg_wdata;
        pge_pkg::REG_TRAIL_DECAY:  trail_decay_r  <= cfg_wdata;
        pge_pkg::REG_DANGER_DECAY: danger_decay_r <= cfg_wdata;
        pge_pkg::REG_DETECT_LEVEL: detect_level_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [GW-1:0] cols_use, rows_use;
  logic [7:0]    cs_use;

  assign cols_use = (grid_cols_r == '0) ? GW'(1) :
                    (grid_cols_r > GW'(pge_pkg::MAX_COLS)) ? GW'(pge_pkg::MAX_COLS) : grid_cols_r;
  assign rows_use = (grid_rows_r == '0) ? GW'(1) :
                    (grid_rows_r > GW'(pge_pkg::MAX_ROWS)) ? GW'(pge_pkg::MAX_ROWS) : grid_rows_r;
  assign cs_use   = (cell_size_r == '0) ? 8'd1 : cell_size_r;

  // transaction fields
  logic        [2:0]               op_r;
  logic        [1:0]               lay_r;
  logic        [LW-1:0]            amt_r;
  logic                            bias_r;
  logic signed [pge_pkg::HEAD_W-1:0] head_r;
  logic        [CW-1:0]            gx_r;
  logic        [RW-1:0]            gy_r;

  pge_pkg::state_t state_r, state_nxt;
  logic            accept;
  assign in_tready = (state_r == pge_pkg::ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  // position dividers
  logic                           div_start, div_x_done, div_y_done;
  logic [pge_pkg::DIVIDEND_W-1:0] qx, qy;
  logic [pge_pkg::DIVIDEND_W-1:0] px, py;

  assign px = in_tdata[15] ? '0 : in_tdata[14:0];
  assign py = in_tdata[31] ? '0 : in_tdata[30:16];
  assign div_start = accept;

  pge_div u_div_x (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(px), .divisor(cs_use),
    .done(div_x_done), .quotient(qx)
  );
  pge_div u_div_y (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(py), .divisor(cs_use),
    .done(div_y_done), .quotient(qy)
  );

  logic [CW-1:0] gx_clamp;
  logic [RW-1:0] gy_clamp;
  assign gx_clamp = (qx > pge_pkg::DIVIDEND_W'(cols_use - 1'b1)) ? CW'(cols_use - 1'b1) : CW'(qx);
  assign gy_clamp = (qy > pge_pkg::DIVIDEND_W'(rows_use - 1'b1)) ? RW'(rows_use - 1'b1) : RW'(qy);

  // cell memory
  logic [LW-1:0] mem [pge_pkg::STORE_CELLS];
  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [LW-1:0] mem_wd, rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  logic [AW-1:0] cell_addr;
  assign cell_addr = {lay_r, gy_r, gx_r};

  // sweep and scan state
  logic [AW-1:0] sweep_idx_r;
  logic          ev_v_r;
  logic [AW-1:0] ev_a_r;
  logic [3:0]    dir_cnt_r;
  logic          dir_v_r, dir_off_r;
  logic [2:0]    dir_k_r;
  logic [31:0]   best_r;
  logic          found_r;
  logic [2:0]    win_r;
  logic [LW-1:0] res_level_r;
  logic          res_kind_r;

  logic          sweep_issue, sweep_last;
  assign sweep_issue = sweep_idx_r < AW'(pge_pkg::STORE_CELLS);
  assign sweep_last  = sweep_idx_r == AW'(pge_pkg::STORE_CELLS - 1);

  // neighbor address
  logic [2:0]           nk;
  logic signed [1:0]    ndx, ndy;
  logic                 noff;
  logic [CW-1:0]        nx;
  logic [RW-1:0]        ny;
  assign nk   = dir_cnt_r[2:0];
  assign ndx  = pge_pkg::nb_dx(nk);
  assign ndy  = pge_pkg::nb_dy(nk);
  assign noff = (ndx < 0 && gx_r == '0) || (ndx > 0 && GW'(gx_r) + 1'b1 >= cols_use) ||
                (ndy < 0 && gy_r == '0) || (ndy > 0 && GW'(gy_r) + 1'b1 >= rows_use);
  assign nx   = gx_r + CW'(ndx);
  assign ny   = gy_r + RW'(ndy);

  // neighbor evaluation
  logic signed [pge_pkg::ANGLE_W-1:0] dang, dwrap, dabs;
  logic                               pen, qual;
  logic [31:0]                        nv;
  always_comb begin
    dang = pge_pkg::nb_angle(dir_k_r) - {{2{head_r[pge_pkg::HEAD_W-1]}}, head_r};
    dwrap = dang;
    if (dwrap > pge_pkg::Q12_PI) dwrap = dwrap - pge_pkg::Q12_TWO_PI;
    if (dwrap < -pge_pkg::Q12_PI) dwrap = dwrap + pge_pkg::Q12_TWO_PI;
    dabs = (dwrap < 0) ? -dwrap : dwrap;
    pen  = bias_r && (dabs > pge_pkg::Q12_HALF_PI);
    nv   = pen ? (32'(rd_data_r) * 32'(pge_pkg::PENALTY_Q16)) : {rd_data_r, 16'd0};
    qual = !dir_off_r && (rd_data_r >= detect_level_r);
  end

  logic [LW:0]   dep_sum;
  logic [31:0]   ev_prod;
  assign dep_sum = {1'b0, rd_data_r} + {1'b0, amt_r};
  assign ev_prod = 32'(rd_data_r) *
                   32'((ev_a_r >= AW'(2 * pge_pkg::LAYER_CELLS)) ? danger_decay_r : trail_decay_r);

  logic out_free;
  assign out_free = !out_tvalid || out_tready;

  // next state and memory strobes
  always_comb begin
    state_nxt = state_r;
    mem_we    = 1'b0;
    mem_wa    = sweep_idx_r;
    mem_wd    = '0;
    mem_ra    = cell_addr;
    case (state_r)
      pge_pkg::ST_INIT, pge_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        if (sweep_last) state_nxt = pge_pkg::ST_IDLE;
      end
      pge_pkg::ST_IDLE: begin
        if (accept) state_nxt = pge_pkg::ST_DIV;
      end
      pge_pkg::ST_DIV: begin
        if (div_x_done && div_y_done) state_nxt = pge_pkg::ST_DISPATCH;
      end
      pge_pkg::ST_DISPATCH: begin
        case (pge_pkg::op_t'(op_r))
          pge_pkg::OP_DEPOSIT:   state_nxt = pge_pkg::ST_DEP_RD;
          pge_pkg::OP_EVAPORATE: state_nxt = pge_pkg::ST_EVAP;
          pge_pkg::OP_CLEAR:     state_nxt = pge_pkg::ST_CLEAR;
          pge_pkg::OP_STRENGTH:  state_nxt = pge_pkg::ST_QRD;
          pge_pkg::OP_DIRECTION: state_nxt = pge_pkg::ST_DIR;
          default:               state_nxt = pge_pkg::ST_IDLE;
        endcase
      end
      pge_pkg::ST_DEP_RD: state_nxt = pge_pkg::ST_DEP_WR;
      pge_pkg::ST_DEP_WR: begin
        mem_we    = 1'b1;
        mem_wa    = cell_addr;
        mem_wd    = (dep_sum > {1'b0, max_level_r}) ? max_level_r : dep_sum[LW-1:0];
        state_nxt = pge_pkg::ST_IDLE;
      end
      pge_pkg::ST_EVAP: begin
        mem_ra = sweep_idx_r;
        mem_we = ev_v_r;
        mem_wa = ev_a_r;
        mem_wd = ev_prod[31:16];
        if (!sweep_issue && !ev_v_r) state_nxt = pge_pkg::ST_IDLE;
      end
      pge_pkg::ST_QRD:   state_nxt = pge_pkg::ST_QDATA;
      pge_pkg::ST_QDATA: state_nxt = pge_pkg::ST_RESP;
      pge_pkg::ST_DIR: begin
        mem_ra = {lay_r, ny, nx};
        if (dir_cnt_r == 4'd8 && !dir_v_r) state_nxt = pge_pkg::ST_RESP;
      end
      pge_pkg::ST_RESP: begin
        if (out_free) state_nxt = pge_pkg::ST_IDLE;
      end
      default: state_nxt = pge_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pge_pkg::ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_idx_r <= '0;
      ev_v_r      <= 1'b0;
      dir_cnt_r   <= '0;
      dir_v_r     <= 1'b0;
    end else begin
      ev_v_r  <= (state_r == pge_pkg::ST_EVAP) && sweep_issue;
      dir_v_r <= (state_r == pge_pkg::ST_DIR) && (dir_cnt_r < 4'd8);
      case (state_r)
        pge_pkg::ST_INIT, pge_pkg::ST_CLEAR: begin
          sweep_idx_r <= sweep_last ? '0 : sweep_idx_r + 1'b1;
        end
        pge_pkg::ST_EVAP: begin
          if (sweep_issue) sweep_idx_r <= sweep_idx_r + 1'b1;
          else if (!ev_v_r) sweep_idx_r <= '0;
        end
        pge_pkg::ST_DISPATCH: dir_cnt_r <= '0;
        pge_pkg::ST_DIR: begin
          if (dir_cnt_r < 4'd8) dir_cnt_r <= dir_cnt_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    ev_a_r    <= sweep_idx_r;
    dir_k_r   <= nk;
    dir_off_r <= noff;
    if (accept) begin
      op_r   <= in_tuser[2:0];
      lay_r  <= (in_tuser[4:3] == 2'd3) ? 2'd1 : in_tuser[4:3];
      amt_r  <= in_tdata[47:32];
      bias_r <= in_tdata[48];
      head_r <= in_tdata[63:49];
    end
    if (state_r == pge_pkg::ST_DIV && div_x_done) begin
      gx_r <= gx_clamp;
      gy_r <= gy_clamp;
    end
    if (state_r == pge_pkg::ST_DISPATCH) begin
      best_r  <= '0;
      found_r <= 1'b0;
      win_r   <= '0;
    end else if (dir_v_r && qual && nv > best_r) begin
      best_r  <= nv;
      found_r <= 1'b1;
      win_r   <= dir_k_r;
    end
    if (state_r == pge_pkg::ST_QDATA) begin
      res_level_r <= rd_data_r;
      res_kind_r  <= 1'b0;
    end else if (state_r == pge_pkg::ST_DIR) begin
      res_level_r <= '0;
      res_kind_r  <= 1'b1;
    end
  end

  // result register
  logic          out_valid_r;
  logic          out_kind_r, out_found_r;
  logic [LW-1:0] out_level_r;
  logic [2:0]    out_dir_r;
  logic          load_out;
  assign load_out = (state_r == pge_pkg::ST_RESP) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_kind_r  <= res_kind_r;
      out_level_r <= res_level_r;
      out_found_r <= res_kind_r && found_r;
      out_dir_r   <= res_kind_r ? win_r : 3'd0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {4'd0, out_dir_r, out_found_r, out_level_r};

  `PGE_ASSERT(a_init_blocks_input, state_r == pge_pkg::ST_INIT |-> !in_tready, "input taken during clearing pass")
  `PGE_ASSERT(a_write_in_range, mem_we |-> mem_wa < AW'(pge_pkg::STORE_CELLS), "cell write out of range")
  `PGE_ASSERT(a_scan_bound, dir_cnt_r <= 4'd8, "neighbor counter overrun")
  `PGE_ASSERT_NR(a_reset_init, !rst_n |=> state_r == pge_pkg::ST_INIT, "reset did not start clearing pass")

endmodule
